FILE: design/mrm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrm_pkg: shared definitions for the 4x4 matrix row multiplier
// Element widths, fixed-point position, product and sum types, and the
// stage-enable bundle that the top level hands to the datapath modules.
// ----------------------------------------------------------------------------
package mrm_pkg;

   localparam int DATA_WIDTH = 32;              // element width inside the datapath
   localparam int FRAC_BITS  = 16;              // fraction bits of the fixed-point format
   localparam int IO_WIDTH   = 32;              // width of the element ports
   localparam int ROW_WIDTH  = 2;
   localparam int DIM        = 4;
   localparam int PROD_WIDTH = 2 * DATA_WIDTH;  // one exact product
   localparam int PAIR_WIDTH = PROD_WIDTH + 1;  // sum of two products
   localparam int SUM_WIDTH  = PROD_WIDTH + 2;  // sum of four products

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_MULTIPLY = 1'b1;

   typedef logic signed [DATA_WIDTH-1:0] elem_type;
   typedef logic signed [IO_WIDTH-1:0]   io_elem_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic signed [PAIR_WIDTH-1:0] pair_type;
   typedef logic signed [SUM_WIDTH-1:0]  sum_type;
   typedef logic        [ROW_WIDTH-1:0]  row_type;

   // Load enables of the pipeline stages, from input side to output side.
   typedef struct packed {
      logic prod;
      logic pair;
      logic sum;
      logic out;
   } stage_en_type;

endpackage : mrm_pkg
`default_nettype wire

FILE: design/mrm_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrm_lane: one column dot product
// Four products of the row with one right-matrix column, then a two-level
// registered adder tree that keeps the sum exact.
// ----------------------------------------------------------------------------
module mrm_lane (
   input  wire logic                 clock,
   input  wire mrm_pkg::stage_en_type en,
   input  wire mrm_pkg::elem_type    row_elem [mrm_pkg::DIM],
   input  wire mrm_pkg::elem_type    col_elem [mrm_pkg::DIM],
   output      mrm_pkg::sum_type     sum_out
);
   import mrm_pkg::*;

   prod_type prod_ff [DIM];
   prod_type prod_in [DIM];
   pair_type pair_a_ff, pair_a_in;
   pair_type pair_b_ff, pair_b_in;
   sum_type  sum_ff, sum_in;

   always_comb begin
      for (int j = 0; j < DIM; j++) begin
         prod_in[j] = PROD_WIDTH'(row_elem[j]) * PROD_WIDTH'(col_elem[j]);
      end
      pair_a_in = PAIR_WIDTH'(prod_ff[0]) + PAIR_WIDTH'(prod_ff[1]);
      pair_b_in = PAIR_WIDTH'(prod_ff[2]) + PAIR_WIDTH'(prod_ff[3]);
      sum_in    = SUM_WIDTH'(pair_a_ff) + SUM_WIDTH'(pair_b_ff);
   end

   always_ff @(posedge clock) begin
      if (en.prod) begin
         for (int j = 0; j < DIM; j++) begin
            prod_ff[j] <= prod_in[j];
         end
      end
      if (en.pair) begin
         pair_a_ff <= pair_a_in;
         pair_b_ff <= pair_b_in;
      end
      if (en.sum) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_out = sum_ff;

endmodule : mrm_lane
`default_nettype wire

FILE: design/mrm_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrm_merge: scaling, saturation and result register
// Shifts each lane sum down to the fixed-point position, clamps it to the
// element range and folds the four clamp events into one overflow flag.
// ----------------------------------------------------------------------------
module mrm_merge (
   input  wire logic                 clock,
   input  wire mrm_pkg::stage_en_type en,
   input  wire mrm_pkg::sum_type     lane_sum [mrm_pkg::DIM],
   input  wire mrm_pkg::row_type     row_in,
   output      mrm_pkg::row_type     out_row,
   output      mrm_pkg::io_elem_type out_elem [mrm_pkg::DIM],
   output      logic                 overflow
);
   import mrm_pkg::*;

   localparam elem_type ELEM_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam elem_type ELEM_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   sum_type     shifted [DIM];
   logic        fits    [DIM];
   io_elem_type elem_in [DIM];
   io_elem_type elem_ff [DIM];
   logic        ovf_in, ovf_ff;
   row_type     row_ff;

   always_comb begin
      ovf_in = 1'b0;
      for (int k = 0; k < DIM; k++) begin
         shifted[k] = lane_sum[k] >>> FRAC_BITS;
         // The value fits when every bit above the element's sign bit
         // repeats that sign bit.
         fits[k] = (&shifted[k][SUM_WIDTH-1:DATA_WIDTH-1]) |
                   ~(|shifted[k][SUM_WIDTH-1:DATA_WIDTH-1]);
         if (fits[k]) begin
            elem_in[k] = IO_WIDTH'(elem_type'(shifted[k][DATA_WIDTH-1:0]));
         end else if (shifted[k][SUM_WIDTH-1]) begin
            elem_in[k] = IO_WIDTH'(ELEM_MIN);
         end else begin
            elem_in[k] = IO_WIDTH'(ELEM_MAX);
         end
         ovf_in = ovf_in | ~fits[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en.out) begin
         for (int k = 0; k < DIM; k++) begin
            elem_ff[k] <= elem_in[k];
         end
         ovf_ff <= ovf_in;
         row_ff <= row_in;
      end
   end

   assign out_elem = elem_ff;
   assign overflow = ovf_ff;
   assign out_row  = row_ff;

endmodule : mrm_merge
`default_nettype wire

FILE: design/matrix4x4_row_multiply.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix4x4_row_multiply: row-at-a-time 4x4 fixed-point matrix product
// Usage: the req_ channel carries one matrix row per transfer. With
// req_op = load the row is stored as row req_row of the right matrix and no
// result follows; the store is seen by every multiply transfer after it.
// With req_op = multiply the row is a row of the left matrix, and one result
// row (the row times the right matrix, Q16.16, saturated, with an overflow
// flag) comes out on the rsp_ channel with req_row echoed in rsp_out_row.
// Pipeline: the clock edge that accepts a multiply transfer loads its
// products, which then pass the pair sums, the full sum and the result
// register before they show on rsp_, so four register stages in all.
// Throughput: one transfer per cycle of either kind while req_ready is high;
// four parallel lanes compute the four columns, each with four multipliers.
// Stalls: each stage has its own valid bit and moves up whenever the stage
// after it is empty or moving, so bubbles close up and new transfers are
// taken while a finished result waits; req_ready falls only when all stages
// hold results. Reset clears the pipeline valid bits and sets the right
// matrix to zero.
// ----------------------------------------------------------------------------
module matrix4x4_row_multiply (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic                  req_op,
   input  wire logic [1:0]            req_row,
   input  wire logic signed [31:0]    req_v0,
   input  wire logic signed [31:0]    req_v1,
   input  wire logic signed [31:0]    req_v2,
   input  wire logic signed [31:0]    req_v3,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [1:0]            rsp_out_row,
   output      logic signed [31:0]    rsp_out0,
   output      logic signed [31:0]    rsp_out1,
   output      logic signed [31:0]    rsp_out2,
   output      logic signed [31:0]    rsp_out3,
   output      logic                  rsp_overflow
);
   import mrm_pkg::*;

   localparam int MAT_ENTRIES = DIM * DIM;
   localparam int COL_BITS    = $clog2(DIM);

   // Right matrix, entry {j,k} holds right[j][k].
   elem_type     rm_ff [MAT_ENTRIES];
   elem_type     row_elem [DIM];
   elem_type     col_elem [DIM][DIM];
   sum_type      lane_sum [DIM];
   io_elem_type  out_elem [DIM];

   stage_en_type en;
   logic         prod_vld_ff, prod_vld_in;
   logic         pair_vld_ff, pair_vld_in;
   logic         sum_vld_ff,  sum_vld_in;
   logic         out_vld_ff,  out_vld_in;
   row_type      prod_row_ff, pair_row_ff, sum_row_ff;
   logic         req_xfer;

   // Stage enables, from the output side back to the input side.
   always_comb begin
      en.out  = ~out_vld_ff  | rsp_ready;
      en.sum  = ~sum_vld_ff  | en.out;
      en.pair = ~pair_vld_ff | en.sum;
      en.prod = ~prod_vld_ff | en.pair;
   end

   assign req_ready = en.prod;
   assign req_xfer  = req_valid & req_ready;

   always_comb begin
      prod_vld_in = en.prod ? (req_xfer & (req_op == OP_MULTIPLY)) : prod_vld_ff;
      pair_vld_in = en.pair ? prod_vld_ff : pair_vld_ff;
      sum_vld_in  = en.sum  ? pair_vld_ff : sum_vld_ff;
      out_vld_in  = en.out  ? sum_vld_ff  : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         pair_vld_ff <= 1'b0;
         sum_vld_ff  <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
         pair_vld_ff <= pair_vld_in;
         sum_vld_ff  <= sum_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // The row index travels alongside the sums.
   always_ff @(posedge clock) begin
      if (en.prod) begin
         prod_row_ff <= req_row;
      end
      if (en.pair) begin
         pair_row_ff <= prod_row_ff;
      end
      if (en.sum) begin
         sum_row_ff <= pair_row_ff;
      end
   end

   // Only the low element bits of each input are used.
   always_comb begin
      row_elem[0] = elem_type'(req_v0[DATA_WIDTH-1:0]);
      row_elem[1] = elem_type'(req_v1[DATA_WIDTH-1:0]);
      row_elem[2] = elem_type'(req_v2[DATA_WIDTH-1:0]);
      row_elem[3] = elem_type'(req_v3[DATA_WIDTH-1:0]);
   end

   // A load transfer writes one whole row. A multiply samples the matrix in
   // the same cycle it is accepted, so later loads never reach it.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAT_ENTRIES; i++) begin
            rm_ff[i] <= '0;
         end
      end else if (req_xfer && (req_op == OP_LOAD)) begin
         for (int k = 0; k < DIM; k++) begin
            rm_ff[{req_row, COL_BITS'(k)}] <= row_elem[k];
         end
      end
   end

   // Lane k sees column k of the right matrix.
   always_comb begin
      for (int k = 0; k < DIM; k++) begin
         for (int j = 0; j < DIM; j++) begin
            col_elem[k][j] = rm_ff[{ROW_WIDTH'(j), COL_BITS'(k)}];
         end
      end
   end

   for (genvar k = 0; k < DIM; k++) begin : g_lane
      mrm_lane u_lane (
         .clock    (clock),
         .en       (en),
         .row_elem (row_elem),
         .col_elem (col_elem[k]),
         .sum_out  (lane_sum[k])
      );
   end

   mrm_merge u_merge (
      .clock    (clock),
      .en       (en),
      .lane_sum (lane_sum),
      .row_in   (sum_row_ff),
      .out_row  (rsp_out_row),
      .out_elem (out_elem),
      .overflow (rsp_overflow)
   );

   assign rsp_valid = out_vld_ff;
   assign rsp_out0  = out_elem[0];
   assign rsp_out1  = out_elem[1];
   assign rsp_out2  = out_elem[2];
   assign rsp_out3  = out_elem[3];

endmodule : matrix4x4_row_multiply
`default_nettype wire

FILE: sim/matrix4x4_row_multiply_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4x4_row_multiply_tb: self-checking bench for the 4x4 row multiplier
// A queue of matrix rows feeds a valid/ready driver. Every accepted transfer
// updates a local copy of the right matrix or, for a multiply, yields the
// expected result row. A monitor compares each result transfer field by
// field with the oldest expected row, under random stalls on both sides.
// ----------------------------------------------------------------------------
module matrix4x4_row_multiply_tb;

   import mrm_pkg::*;

   // One transfer on the request side: the operation, the row index and the
   // four row elements, element k driven onto req_v<k>.
   typedef struct packed {
      logic               op;
      row_type            row;
      io_elem_type [3:0]  v;
   } matrix_row_type;

   // One transfer on the result side.
   typedef struct packed {
      row_type            row;
      io_elem_type [3:0]  elem;
      logic               overflow;
   } product_row_type;

   // The stimulus runs in two equal idling phases and a final no-idle phase,
   // and the receiver holds off once for a long stretch as the sender pushes.
   localparam int unsigned PHASE_LEN    = 600;
   localparam int unsigned RANDOM_ROWS  = 1700;
   localparam int unsigned HOLD_AT      = 1300;
   localparam int unsigned HOLD_CYCLES  = 120;
   localparam int unsigned DRAIN_CYCLES = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_op    = OP_LOAD;
   logic [1:0]        req_row   = '0;
   logic signed [31:0] req_v0   = '0;
   logic signed [31:0] req_v1   = '0;
   logic signed [31:0] req_v2   = '0;
   logic signed [31:0] req_v3   = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_out_row;
   logic signed [31:0] rsp_out0;
   logic signed [31:0] rsp_out1;
   logic signed [31:0] rsp_out2;
   logic signed [31:0] rsp_out3;
   logic              rsp_overflow;

   matrix_row_type  pending_rows[$];
   product_row_type expected_rows[$];
   elem_type        right_matrix[16];

   matrix_row_type  offered_row;
   matrix_row_type  fresh_row;
   product_row_type seen_row;
   product_row_type want_row;

   int unsigned accepted_count = 0;
   int unsigned hold_left      = 0;
   bit          hold_done      = 1'b0;
   int unsigned failures       = 0;

   matrix4x4_row_multiply i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_row      (req_row),
      .req_v0       (req_v0),
      .req_v1       (req_v1),
      .req_v2       (req_v2),
      .req_v3       (req_v3),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_row  (rsp_out_row),
      .rsp_out0     (rsp_out0),
      .rsp_out1     (rsp_out1),
      .rsp_out2     (rsp_out2),
      .rsp_out3     (rsp_out3),
      .rsp_overflow (rsp_overflow)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Computes the product of one left-matrix row with the current right
   // matrix. Each column sum is formed exactly in the full sum width, shifted
   // right arithmetically (so it rounds toward minus infinity), and clamped
   // to the signed 32-bit range. Any clamped column raises the overflow flag.
   function automatic product_row_type multiply_row(matrix_row_type item);
      product_row_type res;
      prod_type        prod;
      sum_type         acc;
      sum_type         shifted;
      res.row      = item.row;
      res.overflow = 1'b0;
      for (int k = 0; k < DIM; k++) begin
         acc = '0;
         for (int j = 0; j < DIM; j++) begin
            prod = prod_type'(item.v[j]) * prod_type'(right_matrix[j*DIM + k]);
            acc  = acc + sum_type'(prod);
         end
         shifted = acc >>> FRAC_BITS;
         // The value fits only if every bit above bit 31 copies the sign.
         if (shifted[SUM_WIDTH-1:IO_WIDTH-1] != {(SUM_WIDTH-IO_WIDTH+1){shifted[SUM_WIDTH-1]}})
         begin
            res.elem[k]  = shifted[SUM_WIDTH-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            res.overflow = 1'b1;
         end else begin
            res.elem[k] = shifted[IO_WIDTH-1:0];
         end
      end
      return res;
   endfunction

   function automatic int unsigned sender_idle_pct(int unsigned count);
      if (count < PHASE_LEN) return 31;
      if (count < 2*PHASE_LEN) return 83;
      return 0;
   endfunction

   function automatic int unsigned receiver_idle_pct(int unsigned count);
      if (count < PHASE_LEN) return 83;
      if (count < 2*PHASE_LEN) return 31;
      return 0;
   endfunction

   // Element values: often small Q16.16 numbers so that the sums land in
   // range, plus mid-size values, the format extremes and raw random words.
   function automatic logic [31:0] random_element();
      int unsigned pick;
      logic [31:0] raw;
      pick = $urandom_range(99);
      raw  = $urandom();
      if (pick < 40) return $urandom_range(2**21) - 2**20;
      if (pick < 55) begin
         case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0001_0000;
            default: return 32'hFFFF_0000;
         endcase
      end
      if (pick < 70) return {{8{raw[23]}}, raw[23:0]};
      return raw;
   endfunction

   function automatic void queue_row(logic op, row_type row, logic [31:0] e0,
                                     logic [31:0] e1, logic [31:0] e2, logic [31:0] e3);
      matrix_row_type item;
      item.op   = op;
      item.row  = row;
      item.v[0] = e0;
      item.v[1] = e1;
      item.v[2] = e2;
      item.v[3] = e3;
      pending_rows.push_back(item);
   endfunction

   // Reset is held from the start and never asserted again.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      foreach (right_matrix[i]) right_matrix[i] = '0;
   end

   // Driver. A transfer completes at an edge where valid and ready are both
   // high; the accepted row is applied to the local right matrix or turned
   // into an expected result at that same edge, in transfer order, so a load
   // is seen by every multiply that follows it. A new row is offered only
   // when the bus is free, and the payload stays put while it waits.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (offered_row.op == OP_LOAD) begin
               for (int k = 0; k < DIM; k++)
                  right_matrix[offered_row.row*DIM + k] = offered_row.v[k];
            end else begin
               expected_rows.push_back(multiply_row(offered_row));
            end
            accepted_count <= accepted_count + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_rows.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct(accepted_count)) begin
               fresh_row = pending_rows.pop_front();
               offered_row <= fresh_row;
               req_op      <= fresh_row.op;
               req_row     <= fresh_row.row;
               req_v0      <= fresh_row.v[0];
               req_v1      <= fresh_row.v[1];
               req_v2      <= fresh_row.v[2];
               req_v3      <= fresh_row.v[3];
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off. Once enough transfers have gone through, the
   // result side is blocked for a fixed stretch; the sender is in its
   // no-idle phase by then, so the pipeline fills and req_ready must drop.
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end else if (!hold_done && accepted_count >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end
      end
   end

   // Monitor. Each result transfer is checked against the oldest expected
   // row; a result with nothing expected is a failure of its own.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen_row.row      = rsp_out_row;
            seen_row.elem[0]  = rsp_out0;
            seen_row.elem[1]  = rsp_out1;
            seen_row.elem[2]  = rsp_out2;
            seen_row.elem[3]  = rsp_out3;
            seen_row.overflow = rsp_overflow;
            if (expected_rows.size() == 0) begin
               $error("Result transfer with no row expected: out_row %0d", seen_row.row);
               failures++;
            end else begin
               want_row = expected_rows.pop_front();
               if (seen_row.row !== want_row.row) begin
                  $error("rsp_out_row: expected %0d, actual %0d", want_row.row, seen_row.row);
                  failures++;
               end
               for (int k = 0; k < DIM; k++) begin
                  if (seen_row.elem[k] !== want_row.elem[k]) begin
                     $error("rsp_out%0d: expected %h, actual %h",
                            k, want_row.elem[k], seen_row.elem[k]);
                     failures++;
                  end
               end
               if (seen_row.overflow !== want_row.overflow) begin
                  $error("rsp_overflow: expected %0d, actual %0d",
                         want_row.overflow, seen_row.overflow);
                  failures++;
               end
            end
         end
         rsp_ready <= (hold_left == 0) &&
                      ($urandom_range(99) >= receiver_idle_pct(accepted_count));
      end
   end

   // Stimulus and end of run.
   initial begin
      // Nothing has been loaded yet, so the right matrix reads as zero.
      queue_row(OP_MULTIPLY, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
      // Identity (1.0 on the diagonal): results echo the left row exactly.
      queue_row(OP_LOAD, 2'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
      queue_row(OP_LOAD, 2'd1, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
      queue_row(OP_LOAD, 2'd2, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
      queue_row(OP_LOAD, 2'd3, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
      queue_row(OP_MULTIPLY, 2'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
      queue_row(OP_MULTIPLY, 2'd2, 32'h0000_0001, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001);
      // Largest positive everywhere: sums saturate high, low, or just fit.
      for (int r = 0; r < DIM; r++)
         queue_row(OP_LOAD, row_type'(r), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF);
      queue_row(OP_MULTIPLY, 2'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_row(OP_MULTIPLY, 2'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      queue_row(OP_MULTIPLY, 2'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);
      // Smallest fraction everywhere: a negative sum rounds down to -1.
      for (int r = 0; r < DIM; r++)
         queue_row(OP_LOAD, row_type'(r), 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
                   32'h0000_0001);
      queue_row(OP_MULTIPLY, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // A reload right before a multiply must already be in effect.
      queue_row(OP_LOAD, 2'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      queue_row(OP_MULTIPLY, 2'd3, 32'h8000_0000, 32'h0, 32'h0, 32'h0);

      for (int i = 0; i < RANDOM_ROWS; i++)
         queue_row($urandom_range(1) ? OP_MULTIPLY : OP_LOAD, row_type'($urandom_range(3)),
                   random_element(), random_element(), random_element(), random_element());

      while (pending_rows.size() != 0 || req_valid) @(posedge clock);
      while (expected_rows.size() != 0) @(posedge clock);
      // Run on for DRAIN_CYCLES so that a stray extra result would still be seen.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule : matrix4x4_row_multiply_tb
